// File: src/consistent_hash_ring_lookup_unit_defines.svh
// Assertion macros for the ring lookup unit.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef CONSISTENT_HASH_RING_LOOKUP_UNIT_DEFINES_SVH
`define CONSISTENT_HASH_RING_LOOKUP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CHR_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("check failed");
`define CHR_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("check failed");
`else
`define CHR_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define CHR_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// File: src/chrl_pkg.sv
// Shared types, operation and status codes for the ring lookup unit.
// Depends on nothing.
package chrl_pkg;
  localparam int TABLE_DEPTH_D  = 1024;
  localparam int NODE_COUNT_D   = 64;
  localparam int KEY_BITS_D     = 64;
  localparam int MAX_REPLICAS_D = 8;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_SUCC    = 3'd2;
  localparam logic [2:0] OP_REPLICA = 3'd3;
  localparam logic [2:0] OP_RANGE   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic CFG_REPL  = 1'b0;
  localparam logic CFG_ALIVE = 1'b1;
  localparam logic [3:0] REPL_RESET = 4'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] ring_key;
    logic [5:0]  owner_node;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_node;
    logic [63:0] range_first;
    logic [63:0] range_last;
    logic [10:0] removed_count;
    logic        last;
  } out_beat_t;
endpackage

// File: src/chrl_ring_mem.sv
// Ring entry store: key and owner per entry, one write port, one read port.
// Depends on chrl_pkg (default depth and key width).
module chrl_ring_mem import chrl_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_D,
  parameter int KW    = KEY_BITS_D,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [KW-1:0] wkey,
  input  logic [5:0]    wown,
  input  logic [AW-1:0] raddr,
  output logic [KW-1:0] rkey,
  output logic [5:0]    rown
);
  logic [KW+5:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wkey, wown};
    {rkey, rown} <= mem[raddr];
  end
endmodule

// File: src/consistent_hash_ring_lookup_unit.sv
// Consistent-hash ring lookup unit: top level, sequencer around the ring store.
// Depends on chrl_pkg, chrl_ring_mem and the assertion macro header.
//
// Usage: input beats (in_valid/in_stall/in_data) carry an operation, key and
// node. Result beats (out_valid/out_stall/out_data) carry status and data;
// "last" marks the final beat of an item. Config writes (cfg_valid/cfg_ready)
// set replication count (index 0) and alive mask (index 1); the user must
// write them only when idle, as the block itself does not enforce it.
// One item is worked at a time through a single-port-read store with a
// registered read; each store access takes an address and a data state.
// Successor: binary search over the entries, then a read of the entry found.
// Insert: search, shift each entry above the insert point up by one, write.
// Remove and key range scan every entry. Replicas: search, then a walk;
// each beat is held until the next owner turns up, so the final one, flagged
// last, leaves after the walk ends. Stalls on earlier beats pause the walk.
// Reset clears the entry count and restores config defaults; the store
// itself has no clearing pass and is read only below the entry count.
// in_stall is high while an item is in progress or a result beat waits.
`include "consistent_hash_ring_lookup_unit_defines.svh"
module consistent_hash_ring_lookup_unit import chrl_pkg::*; #(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_D,
  parameter int NODE_COUNT   = NODE_COUNT_D,
  parameter int KEY_BITS     = KEY_BITS_D,
  parameter int MAX_REPLICAS = MAX_REPLICAS_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_SRCH = 4'd1, S_SRCHW = 4'd2,
    S_DISP = 4'd3, S_SHR = 4'd4, S_SHW = 4'd5, S_SCR = 4'd6, S_SCW = 4'd7,
    S_WKR = 4'd8, S_WKW = 4'd9, S_EMIT = 4'd10, S_INS = 4'd11;

  logic [3:0]  st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]  repl_r;
  logic [63:0] alive_r;
  logic [2:0]  op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [5:0]  node_r;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt, wp_r, wp_nxt;
  logic [CW-1:0] walk_r, walk_nxt;
  logic [6:0]  nrep_r, nrep_nxt;
  logic [63:0] seen_r, seen_nxt;
  logic [5:0]  pend_r, pend_nxt;
  logic        any_r, any_nxt;
  logic [KEY_BITS-1:0] first_r, first_nxt, lastk_r, lastk_nxt;
  out_beat_t   ob_r, ob_nxt;
  logic        ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [KEY_BITS-1:0] wkey, rkey;
  logic [5:0]    wown, rown;

  chrl_ring_mem #(.DEPTH(TABLE_DEPTH), .KW(KEY_BITS), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wkey, .wown, .raddr, .rkey, .rown);

  logic [CW-1:0] mid;
  logic [6:0] limit;
  logic       go_right, alive_own, in_acc;

  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign go_right = (op_r == OP_INSERT) ? (rkey <= key_r) : (rkey < key_r);
  assign alive_own = (32'(rown) < NODE_COUNT) && alive_r[rown] && !seen_r[rown];
  assign limit    = (32'(repl_r) > MAX_REPLICAS) ? 7'(MAX_REPLICAS) : 7'(repl_r);
  assign in_stall = (st_r != S_IDLE) || ov_r;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = ob_r;

  function automatic out_beat_t mk(logic [1:0] s, logic [5:0] n,
      logic [63:0] f, logic [63:0] l, logic [10:0] r, logic lf);
    out_beat_t b;
    b.status = s; b.found_node = n; b.range_first = f; b.range_last = l;
    b.removed_count = r; b.last = lf;
    return b;
  endfunction

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; lo_nxt = lo_r; hi_nxt = hi_r;
    idx_nxt = idx_r; wp_nxt = wp_r; walk_nxt = walk_r; nrep_nxt = nrep_r;
    seen_nxt = seen_r; any_nxt = any_r; first_nxt = first_r; lastk_nxt = lastk_r;
    pend_nxt = pend_r;
    ob_nxt = ob_r; ov_nxt = ov_r && out_stall;
    we = 1'b0; waddr = idx_r[AW-1:0]; wkey = rkey; wown = rown;
    raddr = idx_r[AW-1:0];
    case (st_r)
      S_IDLE: if (in_acc) begin
        lo_nxt = '0; hi_nxt = cnt_r; idx_nxt = '0; wp_nxt = '0;
        any_nxt = 1'b0; nrep_nxt = '0; seen_nxt = '0; walk_nxt = '0;
        case (in_data.operation)
          OP_INSERT: if (32'(cnt_r) >= TABLE_DEPTH) begin
              ob_nxt = mk(ST_FULL, 6'd0, 64'd0, 64'd0, 11'd0, 1'b1); ov_nxt = 1'b1;
            end else st_nxt = S_SRCH;
          OP_SUCC, OP_REPLICA:
            if (cnt_r == '0 || (in_data.operation == OP_REPLICA && limit == '0)) begin
              ob_nxt = mk(ST_NOTFOUND, 6'd0, 64'd0, 64'd0, 11'd0, 1'b1);
              ov_nxt = 1'b1;
            end else st_nxt = S_SRCH;
          OP_REMOVE, OP_RANGE: st_nxt = S_SCR;
          default: begin
            ob_nxt = mk(ST_NOTFOUND, 6'd0, 64'd0, 64'd0, 11'd0, 1'b1); ov_nxt = 1'b1;
          end
        endcase
      end
      S_SRCH: begin
        raddr = mid[AW-1:0];
        st_nxt = (lo_r < hi_r) ? S_SRCHW : S_DISP;
      end
      S_SRCHW: begin
        if (go_right) lo_nxt = mid + 1'b1; else hi_nxt = mid;
        st_nxt = S_SRCH;
      end
      S_DISP: begin
        if (op_r == OP_INSERT) begin
          idx_nxt = cnt_r; st_nxt = S_INS;
        end else begin
          idx_nxt = (lo_r >= cnt_r) ? '0 : lo_r;
          st_nxt = S_WKR;
        end
      end
      S_INS: begin
        // shift entries above the insert point up by one, top first
        if (idx_r > lo_r) begin
          raddr = AW'(idx_r - 1'b1); st_nxt = S_SHW;
        end else begin
          we = 1'b1; wkey = key_r; wown = node_r; cnt_nxt = cnt_r + 1'b1;
          ob_nxt = mk(ST_OK, 6'd0, 64'd0, 64'd0, 11'd0, 1'b1); ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_SHW: begin
        we = 1'b1; idx_nxt = idx_r - 1'b1; st_nxt = S_INS;
      end
      S_SCR: begin
        if (idx_r < cnt_r) st_nxt = S_SCW;
        else begin
          if (op_r == OP_REMOVE) begin
            cnt_nxt = wp_r;
            ob_nxt = mk(ST_OK, 6'd0, 64'd0, 64'd0, 11'(cnt_r - wp_r), 1'b1);
          end else if (any_r)
            ob_nxt = mk(ST_OK, 6'd0, 64'(first_r), 64'(lastk_r), 11'd0, 1'b1);
          else ob_nxt = mk(ST_NOTFOUND, 6'd0, 64'd0, 64'd0, 11'd0, 1'b1);
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      S_SCW: begin
        if (op_r == OP_REMOVE) begin
          if (rown != node_r) begin
            we = 1'b1; waddr = wp_r[AW-1:0]; wp_nxt = wp_r + 1'b1;
          end
        end else if (rown == node_r) begin
          if (!any_r) first_nxt = rkey;
          lastk_nxt = rkey; any_nxt = 1'b1;
        end
        idx_nxt = idx_r + 1'b1; st_nxt = S_SCR;
      end
      S_WKR: begin
        if (walk_r < cnt_r && (op_r == OP_SUCC || nrep_r < limit)) st_nxt = S_WKW;
        else begin
          if (nrep_r == '0) begin
            ob_nxt = mk(ST_NOTFOUND, 6'd0, 64'd0, 64'd0, 11'd0, 1'b1); ov_nxt = 1'b1;
            st_nxt = S_IDLE;
          end else st_nxt = S_EMIT;
        end
      end
      S_WKW: begin
        if (op_r == OP_SUCC) begin
          ob_nxt = mk(ST_OK, rown, 64'd0, 64'd0, 11'd0, 1'b1); ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          // keep one replica in hand; release the previous one when the
          // output register frees up
          if (alive_own) begin
            if (nrep_r == '0 || !ov_r || !out_stall) begin
              if (nrep_r != '0) begin
                ob_nxt = mk(ST_OK, pend_r, 64'd0, 64'd0, 11'd0, 1'b0); ov_nxt = 1'b1;
              end
              pend_nxt = rown;
              seen_nxt = seen_r | (64'd1 << rown); nrep_nxt = nrep_r + 1'b1;
              walk_nxt = walk_r + 1'b1;
              idx_nxt = (idx_r + 1'b1 >= cnt_r) ? '0 : idx_r + 1'b1;
              st_nxt = S_WKR;
            end
          end else begin
            walk_nxt = walk_r + 1'b1;
            idx_nxt = (idx_r + 1'b1 >= cnt_r) ? '0 : idx_r + 1'b1;
            st_nxt = S_WKR;
          end
        end
      end
      S_EMIT: begin
        // send the replica in hand as the final beat
        if (!ov_r || !out_stall) begin
          ob_nxt = mk(ST_OK, pend_r, 64'd0, 64'd0, 11'd0, 1'b1); ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0;
      repl_r <= REPL_RESET; alive_r <= '1;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_REPL) repl_r <= cfg_data[3:0];
        else alive_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_data.operation; key_r <= in_data.ring_key[KEY_BITS-1:0];
      node_r <= in_data.owner_node;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; idx_r <= idx_nxt; wp_r <= wp_nxt;
    walk_r <= walk_nxt; nrep_r <= nrep_nxt; seen_r <= seen_nxt; any_r <= any_nxt;
    first_r <= first_nxt; lastk_r <= lastk_nxt; pend_r <= pend_nxt;
    ob_r <= ob_nxt;
  end

  `CHR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `CHR_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, 32'(cnt_r) <= TABLE_DEPTH)
  `CHR_ASSERT_IMP(a_busy_stall, clk, rst_n, st_r != S_IDLE, in_stall)
endmodule
